### hw/rtl/grc_pkg.sv
// Shared constants and the controller/datapath interface types of the grid ray caster.
// No dependencies; every other file imports this package.
package grc_pkg;

   // Map and number formats
   localparam int MAP_DIM   = 64;
   localparam int CELL_W    = $clog2(MAP_DIM);
   localparam int ADDR_W    = 2 * CELL_W;
   localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = CELL_W + FRAC_BITS;
   localparam int DIR_W     = 16;
   localparam int VAL_W     = 8;
   localparam int LEN_W     = POS_W + 1;
   localparam int SIDE_W    = 2;

   // Working position: one guard cell either side of the map plus sign
   localparam int PX_W      = POS_W + 2;
   localparam int CI_W      = PX_W - FRAC_BITS + 1;

   // Boundary step arithmetic
   localparam int OFF_W     = FRAC_BITS + 2;
   localparam int PROD_W    = DIR_W + OFF_W;
   localparam int NUM_W     = DIR_W + FRAC_BITS;
   localparam int QUO_W     = FRAC_BITS + 2;

   // Length arithmetic
   localparam int SQ_W      = LEN_W;
   localparam int RAD_W     = 2 * SQ_W;
   localparam int ROOT_W    = SQ_W;

   // Counters
   localparam int STEP_CAP  = 2 * MAP_DIM + 4;
   localparam int STEP_W    = $clog2(STEP_CAP + 1);
   localparam int ITER_W    = $clog2(ROOT_W);

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CAST  = 1'b1;

   // Wall side codes
   localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_WEST  = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_EAST  = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clr_step;
      logic wr_cell;
      logic load;
      logic offs;
      logic mul;
      logic pick;
      logic div_step;
      logic update;
      logic diff;
      logic square;
      logic sum;
      logic root_step;
      logic out_hit;
      logic out_miss;
   } grc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic cell_nz;
      logic cell_out;
      logic dir_zero;
   } grc_status_type;

endpackage

### hw/rtl/grc_ctrl.sv
// Controller state machine of the grid ray caster: sequences clearing, cell writes,
// casting and the result handshake. Depends on grc_pkg.
module grc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  grc_pkg::grc_status_type status,
   output grc_pkg::grc_cmd_type    cmd
);
   import grc_pkg::*;

   typedef enum logic [14:0] {
      S_CLEAR = 15'b000000000000001,
      S_IDLE  = 15'b000000000000010,
      S_LOOK  = 15'b000000000000100,
      S_TEST  = 15'b000000000001000,
      S_OFFS  = 15'b000000000010000,
      S_MUL   = 15'b000000000100000,
      S_PICK  = 15'b000000001000000,
      S_DIV   = 15'b000000010000000,
      S_UPD   = 15'b000000100000000,
      S_SQ1   = 15'b000001000000000,
      S_SQ2   = 15'b000010000000000,
      S_SQ3   = 15'b000100000000000,
      S_ROOT  = 15'b001000000000000,
      S_FIN   = 15'b010000000000000,
      S_RSP   = 15'b100000000000000
   } grc_state_type;

   grc_state_type       state_ff, state_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign accept    = req_valid && !req_stall;

   // Next state, counters and commands
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      steps_in = steps_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_CAST) begin
                  cmd.load = 1'b1;
                  steps_in = '0;
                  state_in = S_LOOK;
               end else begin
                  cmd.wr_cell = 1'b1;
               end
            end
         end
         S_LOOK: state_in = S_TEST;
         S_TEST: begin
            priority if (status.cell_out) begin
               cmd.out_miss = 1'b1;
               state_in     = S_RSP;
            end else if (status.cell_nz) begin
               state_in = S_SQ1;
            end else if (status.dir_zero || steps_ff == STEP_W'(STEP_CAP)) begin
               cmd.out_miss = 1'b1;
               state_in     = S_RSP;
            end else begin
               state_in = S_OFFS;
            end
         end
         S_OFFS: begin
            cmd.offs = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            iter_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(QUO_W - 1)) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            steps_in   = steps_ff + STEP_W'(1);
            state_in   = S_LOOK;
         end
         S_SQ1: begin
            cmd.diff = 1'b1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.square = 1'b1;
            state_in   = S_SQ3;
         end
         S_SQ3: begin
            cmd.sum  = 1'b1;
            iter_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            iter_in       = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(ROOT_W - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.out_hit = 1'b1;
            state_in    = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         iter_ff  <= '0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         steps_ff <= steps_in;
      end
   end

endmodule

### hw/rtl/grc_datapath.sv
// Datapath of the grid ray caster: cell memory, boundary stepping with a bit-serial
// divider, and a bit-serial square root for the ray length. Depends on grc_pkg.
module grc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  grc_pkg::grc_cmd_type                cmd,
   output grc_pkg::grc_status_type             status,
   input  logic [grc_pkg::CELL_W-1:0]          req_cell_x,
   input  logic [grc_pkg::CELL_W-1:0]          req_cell_y,
   input  logic [grc_pkg::VAL_W-1:0]           req_cell_value,
   input  logic [grc_pkg::POS_W-1:0]           req_start_x,
   input  logic [grc_pkg::POS_W-1:0]           req_start_y,
   input  logic signed [grc_pkg::DIR_W-1:0]    req_dir_x,
   input  logic signed [grc_pkg::DIR_W-1:0]    req_dir_y,
   output logic [grc_pkg::POS_W-1:0]           rsp_end_x,
   output logic [grc_pkg::POS_W-1:0]           rsp_end_y,
   output logic [grc_pkg::CELL_W-1:0]          rsp_hit_x,
   output logic [grc_pkg::CELL_W-1:0]          rsp_hit_y,
   output logic [grc_pkg::VAL_W-1:0]           rsp_hit_value,
   output logic [grc_pkg::LEN_W-1:0]           rsp_ray_length,
   output logic [grc_pkg::SIDE_W-1:0]          rsp_wall_side,
   output logic                                rsp_left_map
);
   import grc_pkg::*;

   // Offset from a position to the next boundary along a direction
   function automatic logic signed [OFF_W-1:0] bound_off(
      input logic [FRAC_BITS-1:0] frac, input logic pos);
      logic signed [OFF_W-1:0] f;
      f = $signed({2'b00, frac});
      if (pos)              bound_off = (OFF_W'(1) <<< FRAC_BITS) - f;
      else if (frac != '0)  bound_off = -f;
      else                  bound_off = -(OFF_W'(1) <<< FRAC_BITS);
   endfunction

   // Cell index of a position; after the first step a position on a boundary
   // belongs to the cell behind it when moving in the negative direction
   function automatic logic signed [CI_W-1:0] cell_of(
      input logic signed [PX_W-1:0] p, input logic neg, input logic moved);
      logic signed [CI_W-1:0] c;
      c = $signed({p[PX_W-1], p[PX_W-1:FRAC_BITS]});
      if (moved && neg && p[FRAC_BITS-1:0] == '0) c = c - CI_W'(1);
      cell_of = c;
   endfunction

   function automatic logic in_range(input logic signed [CI_W-1:0] c);
      in_range = !c[CI_W-1] && (c < CI_W'(MAP_DIM));
   endfunction

   logic [VAL_W-1:0]           mem [MAP_CELLS];
   logic [VAL_W-1:0]           rd_data_ff;
   logic [ADDR_W-1:0]          clr_ff, clr_in;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;

   logic [POS_W-1:0]           sx_ff, sy_ff;
   logic signed [DIR_W-1:0]    dx_ff, dy_ff;
   logic signed [PX_W-1:0]     px_ff, py_ff, px_in, py_in;
   logic                       moved_ff;
   logic signed [OFF_W-1:0]    ox_ff, oy_ff;
   logic signed [PROD_W-1:0]   pa_ff, pb_ff, pa_in, pb_in;
   logic signed [PROD_W-1:0]   dx_ext, dy_ext, ox_ext, oy_ext;
   logic [NUM_W-1:0]           mag_a, mag_b, num_in;
   logic [DIR_W-1:0]           mag_dx, mag_dy, den_in;
   logic                       xstep_ff, neg_ff;
   logic [DIR_W-1:0]           den_ff, rem_ff, rem_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic [DIR_W:0]             trial;
   logic                       div_ge;
   logic signed [PX_W-1:0]     delta;

   logic signed [CI_W-1:0]     cx, cy;
   logic signed [PX_W:0]       diff_x, diff_y;
   logic [SQ_W-1:0]            ex_ff, ey_ff, ex_in, ey_in;
   logic [RAD_W-1:0]           exsq_ff, eysq_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [ROOT_W+1:0]          srem_ff;
   logic [ROOT_W-1:0]          root_ff;
   logic [ROOT_W+3:0]          sq_cur, sq_try;
   logic                       sq_ge;
   logic [SIDE_W-1:0]          side_in;

   // Current cell and memory addresses
   assign cx      = cell_of(px_ff, dx_ff[DIR_W-1], moved_ff);
   assign cy      = cell_of(py_ff, dy_ff[DIR_W-1], moved_ff);
   assign rd_addr = {cy[CELL_W-1:0], cx[CELL_W-1:0]};
   assign wr_addr = {req_cell_y, req_cell_x};
   assign clr_in  = clr_ff + ADDR_W'(1);

   assign status.clr_last = (clr_ff == ADDR_W'(MAP_CELLS - 1));
   assign status.cell_nz  = (rd_data_ff != '0);
   assign status.cell_out = !(in_range(cx) && in_range(cy));
   assign status.dir_zero = (dx_ff == '0) && (dy_ff == '0);

   // Cell memory: clearing sweep, cell writes, registered read
   always_ff @(posedge clock) begin
      if (cmd.clr_step)     mem[clr_ff]  <= '0;
      else if (cmd.wr_cell) mem[wr_addr] <= req_cell_value;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)             clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_in;
   end

   // Cross products that decide which boundary comes first
   always_comb begin
      dx_ext = dx_ff;
      dy_ext = dy_ff;
      ox_ext = ox_ff;
      oy_ext = oy_ff;
      pa_in  = dy_ext * ox_ext;
      pb_in  = oy_ext * dx_ext;
      mag_a  = pa_ff[PROD_W-1] ? NUM_W'(-pa_ff) : NUM_W'(pa_ff);
      mag_b  = pb_ff[PROD_W-1] ? NUM_W'(-pb_ff) : NUM_W'(pb_ff);
      mag_dx = dx_ff[DIR_W-1] ? DIR_W'(-dx_ff) : DIR_W'(dx_ff);
      mag_dy = dy_ff[DIR_W-1] ? DIR_W'(-dy_ff) : DIR_W'(dy_ff);
      den_in = (mag_a < mag_b) ? mag_dx : mag_dy;
      num_in = ((mag_a < mag_b) ? mag_a : mag_b) + NUM_W'(den_in >> 1);
   end

   // One restoring divide step per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[QUO_W-1]};
      div_ge = trial >= {1'b0, den_ff};
      rem_in = div_ge ? DIR_W'(trial - {1'b0, den_ff}) : trial[DIR_W-1:0];
      quo_in = {quo_ff[QUO_W-2:0], div_ge};
      delta  = neg_ff ? -$signed(PX_W'(quo_ff)) : $signed(PX_W'(quo_ff));
   end

   // Move to the chosen boundary
   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      if (xstep_ff) begin
         px_in = px_ff + PX_W'(ox_ff);
         py_in = py_ff + delta;
      end else begin
         py_in = py_ff + PX_W'(oy_ff);
         px_in = px_ff + delta;
      end
   end

   // Distances from the start and one square root step per cycle
   always_comb begin
      diff_x = $signed({1'b0, px_ff}) - $signed({{(PX_W-POS_W+1){1'b0}}, sx_ff});
      diff_y = $signed({1'b0, py_ff}) - $signed({{(PX_W-POS_W+1){1'b0}}, sy_ff});
      ex_in  = diff_x[PX_W] ? SQ_W'(-diff_x) : SQ_W'(diff_x);
      ey_in  = diff_y[PX_W] ? SQ_W'(-diff_y) : SQ_W'(diff_y);
      sq_cur = {srem_ff, rad_ff[RAD_W-1 -: 2]};
      sq_try = {2'b00, root_ff, 2'b01};
      sq_ge  = sq_cur >= sq_try;
      if (py_ff[FRAC_BITS-1:0] == '0) side_in = dy_ff[DIR_W-1] ? SIDE_NORTH : SIDE_SOUTH;
      else                            side_in = dx_ff[DIR_W-1] ? SIDE_EAST : SIDE_WEST;
   end

   // Advance the working registers as commanded
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff    <= req_start_x;
         sy_ff    <= req_start_y;
         dx_ff    <= req_dir_x;
         dy_ff    <= req_dir_y;
         px_ff    <= PX_W'(req_start_x);
         py_ff    <= PX_W'(req_start_y);
         moved_ff <= 1'b0;
      end
      if (cmd.offs) begin
         ox_ff <= bound_off(px_ff[FRAC_BITS-1:0], !dx_ff[DIR_W-1] && dx_ff != '0);
         oy_ff <= bound_off(py_ff[FRAC_BITS-1:0], !dy_ff[DIR_W-1] && dy_ff != '0);
      end
      if (cmd.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (cmd.pick) begin
         xstep_ff <= mag_a < mag_b;
         neg_ff   <= (mag_a < mag_b) ? (pa_ff[PROD_W-1] != dx_ff[DIR_W-1])
                                     : (pb_ff[PROD_W-1] != dy_ff[DIR_W-1]);
         den_ff   <= den_in;
         rem_ff   <= DIR_W'(num_in[NUM_W-1:QUO_W]);
         quo_ff   <= num_in[QUO_W-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.update) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         moved_ff <= 1'b1;
      end
      if (cmd.diff) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
      end
      if (cmd.square) begin
         exsq_ff <= RAD_W'(ex_ff) * RAD_W'(ex_ff);
         eysq_ff <= RAD_W'(ey_ff) * RAD_W'(ey_ff);
      end
      if (cmd.sum) begin
         rad_ff  <= exsq_ff + eysq_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sq_ge ? (ROOT_W+2)'(sq_cur - sq_try) : sq_cur[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_hit) begin
         rsp_end_x      <= px_ff[POS_W-1:0];
         rsp_end_y      <= py_ff[POS_W-1:0];
         rsp_hit_x      <= cx[CELL_W-1:0];
         rsp_hit_y      <= cy[CELL_W-1:0];
         rsp_hit_value  <= rd_data_ff;
         rsp_ray_length <= root_ff;
         rsp_wall_side  <= side_in;
         rsp_left_map   <= 1'b0;
      end else if (cmd.out_miss) begin
         rsp_end_x      <= '0;
         rsp_end_y      <= '0;
         rsp_hit_x      <= '0;
         rsp_hit_y      <= '0;
         rsp_hit_value  <= '0;
         rsp_ray_length <= '0;
         rsp_wall_side  <= SIDE_NORTH;
         rsp_left_map   <= 1'b1;
      end
   end

endmodule

### hw/rtl/grid_ray_caster.sv
// Grid ray caster, top level: joins the controller and the datapath.
// Depends on grc_pkg, grc_ctrl and grc_datapath.
//
// After reset the block sweeps its 4096-cell map to zero, one cell a cycle, and takes no
// transaction until the sweep ends. A cell write gives no result. A cast tests the start
// cell; for each boundary the ray crosses it forms offsets and cross products, picks the
// nearer boundary, runs the bit-serial divider, moves; on a hit it squares and sums the
// distances and runs the bit-serial square root into the result register. A miss is
// one leaving the map, with no direction or after 132 boundaries. One transaction is
// worked on at a time: the request side stalls until the result has been taken.
module grid_ray_caster (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [grc_pkg::CELL_W-1:0]          req_cell_x,
   input  logic [grc_pkg::CELL_W-1:0]          req_cell_y,
   input  logic [grc_pkg::VAL_W-1:0]           req_cell_value,
   input  logic [grc_pkg::POS_W-1:0]           req_start_x,
   input  logic [grc_pkg::POS_W-1:0]           req_start_y,
   input  logic signed [grc_pkg::DIR_W-1:0]    req_dir_x,
   input  logic signed [grc_pkg::DIR_W-1:0]    req_dir_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [grc_pkg::POS_W-1:0]           rsp_end_x,
   output logic [grc_pkg::POS_W-1:0]           rsp_end_y,
   output logic [grc_pkg::CELL_W-1:0]          rsp_hit_x,
   output logic [grc_pkg::CELL_W-1:0]          rsp_hit_y,
   output logic [grc_pkg::VAL_W-1:0]           rsp_hit_value,
   output logic [grc_pkg::LEN_W-1:0]           rsp_ray_length,
   output logic [grc_pkg::SIDE_W-1:0]          rsp_wall_side,
   output logic                                rsp_left_map
);
   import grc_pkg::*;

   grc_cmd_type    cmd;
   grc_status_type status;

   // Sequence the work
   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Map, stepping and length arithmetic
   grc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_value (req_cell_value),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .rsp_end_x      (rsp_end_x),
      .rsp_end_y      (rsp_end_y),
      .rsp_hit_x      (rsp_hit_x),
      .rsp_hit_y      (rsp_hit_y),
      .rsp_hit_value  (rsp_hit_value),
      .rsp_ray_length (rsp_ray_length),
      .rsp_wall_side  (rsp_wall_side),
      .rsp_left_map   (rsp_left_map)
   );

endmodule

### hw/rtl/grc_checker.sv
// Port-level checks for the grid ray caster, and the bind that attaches them.
// Depends on grc_pkg and grid_ray_caster.
module grc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [grc_pkg::POS_W-1:0]           rsp_end_x,
   input logic [grc_pkg::POS_W-1:0]           rsp_end_y,
   input logic [grc_pkg::VAL_W-1:0]           rsp_hit_value,
   input logic [grc_pkg::LEN_W-1:0]           rsp_ray_length,
   input logic                                rsp_left_map
);
   import grc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Take no request while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while result pending");

   // Stall after an accepted cast transaction
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_CAST |=> req_stall)
      else $error("cast did not occupy the block");

   // A miss carries zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_left_map |-> rsp_end_x == '0 && rsp_end_y == '0 &&
                                    rsp_hit_value == '0 && rsp_ray_length == '0)
      else $error("miss result with nonzero fields");

   // A hit always reports a wall cell
   a_hit_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_left_map |-> rsp_hit_value != '0)
      else $error("hit on open floor");

endmodule

bind grid_ray_caster grc_checker u_grc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_end_x      (rsp_end_x),
   .rsp_end_y      (rsp_end_y),
   .rsp_hit_value  (rsp_hit_value),
   .rsp_ray_length (rsp_ray_length),
   .rsp_left_map   (rsp_left_map)
);

### dv/grid_ray_caster_test.sv
// Self-checking testbench for grid_ray_caster: map writes and ray casts with random gaps.
// Depends on grc_pkg and the grid_ray_caster RTL; predicts every cast result itself.
module grid_ray_caster_test;
   import grc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM       = 1200;
   localparam int N_DIRECTED     = 14;

   typedef struct packed {
      logic [POS_W-1:0]  end_x;
      logic [POS_W-1:0]  end_y;
      logic [CELL_W-1:0] hit_x;
      logic [CELL_W-1:0] hit_y;
      logic [VAL_W-1:0]  hit_value;
      logic [LEN_W-1:0]  ray_length;
      logic [SIDE_W-1:0] wall_side;
      logic              left_map;
   } cast_result_type;

   typedef struct packed {
      logic              mode;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [VAL_W-1:0]  cell_value;
      logic [POS_W-1:0]  start_x;
      logic [POS_W-1:0]  start_y;
      logic [DIR_W-1:0]  dir_x;
      logic [DIR_W-1:0]  dir_y;
   } ray_request_type;

   typedef struct {
      ray_request_type req;
      logic            typed;
      cast_result_type res;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall, req_mode;
   logic [CELL_W-1:0] req_cell_x, req_cell_y;
   logic [VAL_W-1:0]  req_cell_value;
   logic [POS_W-1:0]  req_start_x, req_start_y;
   logic signed [DIR_W-1:0] req_dir_x, req_dir_y;
   logic rsp_valid, rsp_stall;
   logic [POS_W-1:0]  rsp_end_x, rsp_end_y;
   logic [CELL_W-1:0] rsp_hit_x, rsp_hit_y;
   logic [VAL_W-1:0]  rsp_hit_value;
   logic [LEN_W-1:0]  rsp_ray_length;
   logic [SIDE_W-1:0] rsp_wall_side;
   logic              rsp_left_map;

   logic [VAL_W-1:0] map_model [MAP_CELLS];
   cast_result_type  expected_casts [$];
   int  error_count = 0;
   int  casts_seen = 0, hits_seen = 0, misses_seen = 0;
   int  idle_cycles = 0;
   bit  long_hold = 0;
   bit  stim_done = 0;

   grid_ray_caster u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Magnitude of a signed value
   function automatic longint unsigned mag_of(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Quotient rounded to nearest, ties away from zero
   function automatic longint round_div(longint num, longint den);
      longint unsigned n, d, q;
      n = mag_of(num);
      d = mag_of(den);
      q = (n + d / 2) / d;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, t;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         t = root | (64'd1 << i);
         if (t * t <= v) root = t;
      end
      return root;
   endfunction

   function automatic longint next_boundary(longint p, longint d);
      longint frac;
      frac = p & ((64'd1 << FRAC_BITS) - 1);
      if (d > 0) return (64'd1 << FRAC_BITS) - frac;
      return -(frac != 0 ? frac : (64'd1 << FRAC_BITS));
   endfunction

   function automatic longint cell_index(longint p, longint d);
      longint c;
      if (p < 0) return -1;
      c = p >>> FRAC_BITS;
      if ((p & ((64'd1 << FRAC_BITS) - 1)) == 0 && d < 0) c = c - 1;
      return c;
   endfunction

   function automatic bit on_map(longint cx, longint cy);
      return cx >= 0 && cx < MAP_DIM && cy >= 0 && cy < MAP_DIM;
   endfunction

   // Walk the ray boundary by boundary through the model map
   function automatic cast_result_type trace_ray(ray_request_type r);
      cast_result_type res;
      longint sx, sy, dx, dy, px, py, cx, cy, ox, oy;
      longint unsigned ex, ey;
      bit hit;
      res = '0;
      sx = r.start_x;
      sy = r.start_y;
      dx = longint'($signed(r.dir_x));
      dy = longint'($signed(r.dir_y));
      px = sx;
      py = sy;
      cx = sx >>> FRAC_BITS;
      cy = sy >>> FRAC_BITS;
      hit = 0;
      if (on_map(cx, cy) && map_model[cy * MAP_DIM + cx] != 0) begin
         hit = 1;
      end else if (on_map(cx, cy) && (dx != 0 || dy != 0)) begin
         for (int n = 0; n < STEP_CAP; n++) begin
            ox = next_boundary(px, dx);
            oy = next_boundary(py, dy);
            if (mag_of(dy * ox) < mag_of(oy * dx)) begin
               px += ox;
               py += round_div(ox * dy, dx);
            end else begin
               py += oy;
               px += round_div(oy * dx, dy);
            end
            cx = cell_index(px, dx);
            cy = cell_index(py, dy);
            if (!on_map(cx, cy)) break;
            if (map_model[cy * MAP_DIM + cx] != 0) begin
               hit = 1;
               break;
            end
         end
      end
      if (!hit) begin
         res.left_map = 1'b1;
         return res;
      end
      ex = mag_of(px - sx);
      ey = mag_of(py - sy);
      res.end_x = px[POS_W-1:0];
      res.end_y = py[POS_W-1:0];
      res.hit_x = cx[CELL_W-1:0];
      res.hit_y = cy[CELL_W-1:0];
      res.hit_value = map_model[cy * MAP_DIM + cx];
      res.ray_length = LEN_W'(int_sqrt(ex * ex + ey * ey));
      if ((py & ((64'd1 << FRAC_BITS) - 1)) == 0)
         res.wall_side = dy >= 0 ? SIDE_SOUTH : SIDE_NORTH;
      else
         res.wall_side = dx >= 0 ? SIDE_WEST : SIDE_EAST;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Apply a transaction to the model and queue its expectation
   function automatic void absorb_request(ray_request_type r, bit typed,
                                          cast_result_type typed_res);
      cast_result_type pred;
      if (r.mode == MODE_WRITE) begin
         map_model[{r.cell_y, r.cell_x}] = r.cell_value;
         return;
      end
      pred = trace_ray(r);
      if (typed && pred != typed_res)
         $display("note: typed row disagrees with prediction");
      expected_casts.push_back(typed ? typed_res : pred);
   endfunction

   function automatic ray_request_type make_write(int x, int y, int v);
      ray_request_type r;
      r = '0;
      r.mode = MODE_WRITE;
      r.cell_x = CELL_W'(x);
      r.cell_y = CELL_W'(y);
      r.cell_value = VAL_W'(v);
      return r;
   endfunction

   function automatic ray_request_type make_cast(int sx, int sy, int dx, int dy);
      ray_request_type r;
      r = '0;
      r.mode = MODE_CAST;
      r.start_x = POS_W'(sx);
      r.start_y = POS_W'(sy);
      r.dir_x = DIR_W'(dx);
      r.dir_y = DIR_W'(dy);
      r.cell_x = CELL_W'($urandom);
      r.cell_y = CELL_W'($urandom);
      r.cell_value = VAL_W'($urandom);
      return r;
   endfunction

   // Map writes anywhere, casts starting anywhere on the map, some fully random casts
   function automatic ray_request_type random_request();
      ray_request_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r = make_write($urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255));
      end else if (pick < 90) begin
         r = make_cast($urandom_range(0, (MAP_DIM << FRAC_BITS) - 1),
                       $urandom_range(0, (MAP_DIM << FRAC_BITS) - 1),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
         if ($urandom_range(0, 7) == 0) r.dir_x = '0;
         else if ($urandom_range(0, 7) == 0) r.dir_y = '0;
         if ($urandom_range(0, 9) == 0) r.start_x[FRAC_BITS-1:0] = '0;
      end else begin
         r = make_cast($urandom, $urandom, $urandom, $urandom);
      end
      return r;
   endfunction

   task automatic send_request(ray_request_type r);
      req_valid      <= 1'b1;
      req_mode       <= r.mode;
      req_cell_x     <= r.cell_x;
      req_cell_y     <= r.cell_y;
      req_cell_value <= r.cell_value;
      req_start_x    <= r.start_x;
      req_start_y    <= r.start_y;
      req_dir_x      <= r.dir_x;
      req_dir_y      <= r.dir_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 60) : $urandom_range(0, 2);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stimulus: reset, directed table, then random traffic
   initial begin
      stim_row_type rows [N_DIRECTED];
      cast_result_type miss, t;
      ray_request_type r;
      miss = '0;
      miss.left_map = 1'b1;
      foreach (map_model[i]) map_model[i] = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_WRITE;
      req_cell_x = '0;
      req_cell_y = '0;
      req_cell_value = '0;
      req_start_x = '0;
      req_start_y = '0;
      req_dir_x = '0;
      req_dir_y = '0;

      // Empty map: any ray leaves, zero direction leaves, far start leaves
      rows[0] = '{make_cast(32 << 16, 32 << 16, 16384, 0), 1'b1, miss};
      rows[1] = '{make_cast(32 << 16, 32 << 16, 0, 0), 1'b1, miss};
      rows[2] = '{make_cast(22'h3FFFFF, 22'h3FFFFF, -32768, -32768), 1'b1, miss};
      rows[3] = '{make_cast(64 << 16, 5 << 16, -16384, 0), 1'b1, miss};
      // Walls at two corners and at cell (10,10), with extremes of value
      rows[4] = '{make_write(63, 63, 255), 1'b0, miss};
      rows[5] = '{make_write(0, 0, 1), 1'b0, miss};
      rows[6] = '{make_write(10, 10, 128), 1'b0, miss};
      // Hit at start: end equals start, length zero
      t = '0;
      t.end_x = POS_W'((10 << 16) + 5);
      t.end_y = POS_W'((10 << 16) + 7);
      t.hit_x = CELL_W'(10);
      t.hit_y = CELL_W'(10);
      t.hit_value = VAL_W'(128);
      t.wall_side = SIDE_WEST;
      rows[7] = '{make_cast((10 << 16) + 5, (10 << 16) + 7, 0, 0), 1'b1, t};
      rows[8] = '{make_cast(5 << 16, 10 << 16 | 16'h8000, 16384, 0), 1'b0, miss};
      rows[9] = '{make_cast(10 << 16 | 16'h8000, 20 << 16, 0, -16384), 1'b0, miss};
      rows[10] = '{make_cast(32 << 16, 32 << 16, 32767, 32767), 1'b0, miss};
      rows[11] = '{make_cast(5 << 16, 5 << 16, -32768, -32767), 1'b0, miss};
      rows[12] = '{make_write(10, 10, 0), 1'b0, miss};
      rows[13] = '{make_cast(15 << 16, 10 << 16, -16384, 0), 1'b0, miss};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         absorb_request(rows[i].req, rows[i].typed, rows[i].res);
         send_request(rows[i].req);
         sender_gap();
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         r = random_request();
         absorb_request(r, 1'b0, miss);
         send_request(r);
         if (i == N_RANDOM / 2) begin
            // Drain before carrying on
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_casts.size() != 0);
         end else begin
            sender_gap();
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver stalls, with one long hold-off early on
   initial begin
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold && casts_seen >= 5) begin
            long_hold = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 15) == 0 ? $urandom_range(10, 80)
                                              : $urandom_range(1, 3)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      cast_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         casts_seen++;
         if (rsp_left_map) misses_seen++; else hits_seen++;
         if (expected_casts.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = expected_casts.pop_front();
            if (rsp_end_x != want.end_x) report_mismatch("end_x", rsp_end_x, want.end_x);
            if (rsp_end_y != want.end_y) report_mismatch("end_y", rsp_end_y, want.end_y);
            if (rsp_hit_x != want.hit_x) report_mismatch("hit_x", rsp_hit_x, want.hit_x);
            if (rsp_hit_y != want.hit_y) report_mismatch("hit_y", rsp_hit_y, want.hit_y);
            if (rsp_hit_value != want.hit_value)
               report_mismatch("hit_value", rsp_hit_value, want.hit_value);
            if (rsp_ray_length != want.ray_length)
               report_mismatch("ray_length", rsp_ray_length, want.ray_length);
            if (rsp_wall_side != want.wall_side)
               report_mismatch("wall_side", rsp_wall_side, want.wall_side);
            if (rsp_left_map != want.left_map)
               report_mismatch("left_map", rsp_left_map, want.left_map);
         end
      end
   end

   // Watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_casts.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Wrap up once everything has drained
   initial begin
      wait (stim_done);
      while (expected_casts.size() != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      $display("covered %0d casts (%0d hits, %0d left the map) and map writes",
               casts_seen, hits_seen, misses_seen);
      $display("with random gaps, one long receiver hold-off and one full drain");
      if (error_count == 0 && expected_casts.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
